// File: design/tagged_hex_word_extractor_top_defines.svh
// ----------------------------------------------------------------------------
// Tagged hex word extractor: assertion macros
// Shared concurrent assertion shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef TAGGED_HEX_WORD_EXTRACTOR_TOP_DEFINES_SVH
`define TAGGED_HEX_WORD_EXTRACTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define THWE_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define THWE_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/thwe_pkg.sv
// ----------------------------------------------------------------------------
// Tagged hex word extractor package
// Shared constants, register codes and the front-to-back job record.
// ----------------------------------------------------------------------------
package thwe_pkg;

  // Job queue depth, a power of two
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Result slots of one job, emitted lowest first:
  // tag bytes 0..3 (first tag byte first), plain byte, space, decoded word
  localparam int unsigned NumSlots  = 7;
  localparam int unsigned SlotTag0  = 0;
  localparam int unsigned SlotTag1  = 1;
  localparam int unsigned SlotTag2  = 2;
  localparam int unsigned SlotTag3  = 3;
  localparam int unsigned SlotByte  = 4;
  localparam int unsigned SlotSpace = 5;
  localparam int unsigned SlotWord  = 6;

  localparam logic [31:0] TagReset  = 32'h3A58443A;
  localparam logic [7:0]  SpaceChar = 8'h20;
  localparam logic [3:0]  LastDigit = 4'd15;
  localparam logic [2:0]  WinFull   = 3'd4;

  localparam logic KindByte = 1'b0;
  localparam logic KindWord = 1'b1;

  typedef enum logic {
    CfgTagWord  = 1'b0,
    CfgEchoMode = 1'b1
  } cfg_idx_e;

  typedef logic [NumSlots-1:0] slot_mask_t;

  typedef struct packed {
    slot_mask_t  mask;
    logic [31:0] tag;
    logic [7:0]  ch;
    logic [63:0] word;
  } job_t;

endpackage

// File: design/tagged_hex_word_extractor_top.sv
// ----------------------------------------------------------------------------
// Tagged hex word extractor
// Byte stream filter: passes bytes through a four-byte window and decodes
// the sixteen hex digits that follow a 32-bit tag into a 64-bit word.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  --------------------------
//   cfg      in         cfg_we_i                  cfg_idx_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o   in_byte_i
//   out      out        out_valid_o / out_stall_i out_kind_o, out_payload_o,
//                                                 out_last_o
//
// The front end takes one byte per cycle while the job queue has room; the
// back end sends one result per cycle while the output is not stalled, so a
// byte can cause up to five results and the queue soaks up bursts.
// A result passes through the job queue and then the output register.
// Reset is asynchronous and clears all control state; the tag returns to
// ":XD:" and echo mode to off. No clearing pass follows reset.
// A stalled output holds its request; the front end stalls only on a full queue.
//
module tagged_hex_word_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [63:0] out_payload_o,
  output logic        out_last_o
);
  import thwe_pkg::*;

  // Front to queue: one job per byte that produces output
  job_t push_job;
  logic push;
  // Queue to back: head job and pop
  job_t head_job;
  logic empty, full, pop;

  // Classify each byte: window shifting, tag match, hex field assembly
  thwe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Decouple input rate from output bursts
  thwe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head_job),
    .empty_o (empty),
    .full_o  (full)
  );

  // Expand each job into its ordered results, mark the last one
  thwe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_job),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_kind_o    (out_kind_o),
    .out_payload_o (out_payload_o),
    .out_last_o    (out_last_o)
  );

endmodule

// File: design/thwe_front.sv
// ----------------------------------------------------------------------------
// Tagged hex word extractor front end
// Holds config, the byte window and the field decoder; turns each byte into
// a job that lists the results it causes.
// ----------------------------------------------------------------------------
module thwe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  output logic          in_stall_o,
  input  logic          full_i,
  output logic          push_o,
  output thwe_pkg::job_t job_o
);
  import thwe_pkg::*;

  logic [31:0] tag_q;
  logic        echo_q;
  logic [31:0] window_q, window_d, win_eff;
  logic [2:0]  fill_q, fill_d, fill_eff;
  logic        in_field_q, in_field_d, field_eff;
  logic [3:0]  cnt_q, cnt_d, cnt_eff;
  logic [63:0] acc_q, acc_d, acc_eff, acc_shift;
  logic        accept, enter, hex_ok;
  logic [3:0]  hex_val;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= TagReset;
      echo_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTagWord:  tag_q  <= cfg_data_i;
        CfgEchoMode: echo_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Hex digit decode, either case
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = in_byte_i[3:0];
    case (in_byte_i) inside
      [8'h30:8'h39]: hex_val = in_byte_i[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: hex_val = 4'(in_byte_i[3:0] + 4'd9);
      default:       hex_ok  = 1'b0;
    endcase
  end

  always_comb begin
    accept    = in_valid_i && !full_i;
    // A window matching the tag opens the field on this byte
    enter     = !in_field_q && (window_q == tag_q);
    win_eff   = enter ? '0 : window_q;
    fill_eff  = enter ? '0 : fill_q;
    field_eff = in_field_q || enter;
    cnt_eff   = enter ? '0 : cnt_q;
    acc_eff   = enter ? '0 : acc_q;
    acc_shift = {acc_eff[59:0], hex_val};

    window_d   = win_eff;
    fill_d     = fill_eff;
    in_field_d = field_eff;
    cnt_d      = cnt_eff;
    acc_d      = acc_eff;

    job      = '0;
    job.tag  = tag_q;
    job.ch   = in_byte_i;
    job.word = acc_shift;
    job.mask[SlotTag3:SlotTag0] = {4{enter && echo_q}};

    if (!field_eff) begin
      if (fill_eff == WinFull) begin
        job.mask[SlotByte] = 1'b1;
        job.ch             = win_eff[31:24];
      end else begin
        fill_d = 3'(fill_eff + 3'd1);
      end
      window_d = {win_eff[23:0], in_byte_i};
    end else begin
      job.mask[SlotByte] = echo_q;
      if (!hex_ok) begin
        in_field_d = 1'b0;
        cnt_d      = '0;
        acc_d      = '0;
      end else if (cnt_eff == LastDigit) begin
        job.mask[SlotSpace] = echo_q;
        job.mask[SlotWord]  = 1'b1;
        in_field_d = 1'b0;
        cnt_d      = '0;
        acc_d      = '0;
      end else begin
        acc_d = acc_shift;
        cnt_d = 4'(cnt_eff + 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      fill_q     <= '0;
      in_field_q <= 1'b0;
      cnt_q      <= '0;
      acc_q      <= '0;
    end else if (accept) begin
      window_q   <= window_d;
      fill_q     <= fill_d;
      in_field_q <= in_field_d;
      cnt_q      <= cnt_d;
      acc_q      <= acc_d;
    end
  end

  assign in_stall_o = full_i;
  assign push_o     = accept && (|job.mask);
  assign job_o      = job;

endmodule

// File: design/thwe_queue.sv
// ----------------------------------------------------------------------------
// Tagged hex word extractor job queue
// Small register FIFO between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module thwe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  thwe_pkg::job_t job_i,
  input  logic           pop_i,
  output thwe_pkg::job_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import thwe_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCntW'(QDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= QPtrW'(wr_ptr_q + 1'b1);
      if (do_pop)  rd_ptr_q <= QPtrW'(rd_ptr_q + 1'b1);
      if (do_push && !do_pop) begin
        count_q <= QCntW'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= QCntW'(count_q - 1'b1);
      end
    end
  end

endmodule

// File: design/thwe_back.sv
// ----------------------------------------------------------------------------
// Tagged hex word extractor back end
// Walks the result slots of the head job, one result per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module thwe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  thwe_pkg::job_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic           out_kind_o,
  output logic [63:0]    out_payload_o,
  output logic           out_last_o
);
  import thwe_pkg::*;

  slot_mask_t  done_q, done_d, rem, sel, left;
  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d, last_q;
  logic [63:0] payload_q, payload_d;
  logic        advance, emit;

  always_comb begin
    rem     = head_i.mask & ~done_q;
    sel     = rem & slot_mask_t'(~rem + 1'b1);
    left    = rem & ~sel;
    advance = !out_valid_q || !out_stall_i;
    emit    = advance && !empty_i;
    pop_o   = emit && (left == '0);

    done_d = done_q;
    if (emit) begin
      done_d = pop_o ? '0 : (done_q | sel);
    end

    out_valid_d = emit ? 1'b1 : !advance;

    kind_d    = KindByte;
    payload_d = '0;
    if (sel[SlotWord]) begin
      kind_d    = KindWord;
      payload_d = head_i.word;
    end else if (sel[SlotSpace]) begin
      payload_d[7:0] = SpaceChar;
    end else if (sel[SlotByte]) begin
      payload_d[7:0] = head_i.ch;
    end else if (sel[SlotTag3]) begin
      payload_d[7:0] = head_i.tag[7:0];
    end else if (sel[SlotTag2]) begin
      payload_d[7:0] = head_i.tag[15:8];
    end else if (sel[SlotTag1]) begin
      payload_d[7:0] = head_i.tag[23:16];
    end else begin
      payload_d[7:0] = head_i.tag[31:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q    <= kind_d;
      payload_q <= payload_d;
      last_q    <= pop_o;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = kind_q;
  assign out_payload_o = payload_q;
  assign out_last_o    = last_q;

endmodule

// File: design/thwe_checker.sv
// ----------------------------------------------------------------------------
// Tagged hex word extractor port checker
// Watches the top-level ports and flags result streams that break the rules.
// ----------------------------------------------------------------------------
`include "tagged_hex_word_extractor_top_defines.svh"

module thwe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_kind_o,
  input logic [63:0] out_payload_o,
  input logic        out_last_o
);

  // A decoded word always closes the results of its byte
  `THWE_ASSERT_IMPL(a_word_is_last, clk_i, rst_ni, out_valid_o && out_kind_o, out_last_o, "decoded word not marked last")

  // Plain bytes carry zeros above bit 7
  `THWE_ASSERT_IMPL(a_byte_upper_zero, clk_i, rst_ni, out_valid_o && !out_kind_o, out_payload_o[63:8] == 56'd0, "plain byte with nonzero upper payload")

  // Hold a stalled request
  `THWE_ASSERT_NEXT(a_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "output request dropped while stalled")

  `THWE_ASSERT_NEXT(a_payload_held, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_payload_o), "stalled payload changed")

endmodule

bind tagged_hex_word_extractor_top thwe_checker u_thwe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_kind_o    (out_kind_o),
  .out_payload_o (out_payload_o),
  .out_last_o    (out_last_o)
);
